// ===== hw/rtl/sha_pkg.sv =====
// sha_pkg: constants, types and round functions shared by the sha-256 block
// no dependencies
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    FILL_MSG  = 3'b001,
    FILL_PAD  = 3'b010,
    FILL_ZERO = 3'b100
  } fill_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      buf_wr;
    fill_sel_t buf_sel;
    logic      cnt_inc;
    logic      cnt_clr;
    logic      len_wr;
    logic      comp_start;
    logic      round_en;
    logic      chain_upd;
    logic      chain_init;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
  } dp_stat_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    word_t k [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    round_k = k[r];
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                     32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    init_hash = h[i];
  endfunction

endpackage

// ===== hw/rtl/sha_datapath.sv =====
// sha_datapath: block buffer, length counter, message schedule and round unit
// depends on sha_pkg
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  rd_index,
  output dp_stat_t    stat,
  output word_t       rd_word
);

  // block held as sixteen big-endian words, bytes land in their lanes
  word_t       block_buffer [BlockBytes / 4];
  logic [60:0] byte_total;
  word_t       w [16];
  word_t       v [8];
  word_t       chain_value [8];
  logic [5:0]  round;
  logic [5:0]  fill;

  word_t       w_new, t1, t2, s0, s1;
  logic [63:0] bit_len;
  logic [7:0]  wr_data;

  assign bit_len = {byte_total, 3'b000};
  assign stat    = '{fill: fill, round: round};
  assign rd_word = chain_value[rd_index];

  always_comb begin
    unique case (cmd.buf_sel)
      FILL_MSG:  wr_data = data_byte;
      FILL_PAD:  wr_data = PadByte;
      default:   wr_data = 8'h00;
    endcase
  end

  // schedule kept as a shifting window: w[0] is the word for this round
  always_comb begin
    s0    = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1    = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round) + w[0];
    t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      block_buffer[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_data;
    end
    if (cmd.len_wr) begin
      block_buffer[4'(LenPos / 4)]     <= bit_len[63:32];
      block_buffer[4'(LenPos / 4 + 1)] <= bit_len[31:0];
    end
    if (cmd.comp_start) begin
      for (int j = 0; j < 16; j++) begin
        w[j] <= block_buffer[j];
      end
      for (int j = 0; j < 8; j++) begin
        v[j] <= chain_value[j];
      end
    end else if (cmd.round_en) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
      fill       <= '0;
      round      <= '0;
      for (int j = 0; j < 8; j++) chain_value[j] <= init_hash(3'(j));
    end else begin
      if (cmd.cnt_clr) begin
        byte_total <= '0;
      end else if (cmd.cnt_inc) begin
        byte_total <= byte_total + 61'd1;
      end
      // buffer position advances on every written byte, pad and zero included
      if (cmd.cnt_clr) begin
        fill <= '0;
      end else if (cmd.buf_wr) begin
        fill <= fill + 6'd1;
      end
      if (cmd.comp_start) begin
        round <= '0;
      end else if (cmd.round_en) begin
        round <= round + 6'd1;
      end
      if (cmd.chain_init) begin
        for (int j = 0; j < 8; j++) chain_value[j] <= init_hash(3'(j));
      end else if (cmd.chain_upd) begin
        for (int j = 0; j < 8; j++) chain_value[j] <= chain_value[j] + v[j];
      end
    end
  end

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// sha_ctrl: sequencer for byte intake, padding, compression and digest output
// depends on sha_pkg
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       ready,
  input  logic       has_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] word_index,
  output logic       last_word,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOAD  = 8'b00000010,
    S_ROUND = 8'b00000100,
    S_UPD   = 8'b00001000,
    S_PAD   = 8'b00010000,
    S_ZERO  = 8'b00100000,
    S_LEN   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t     state, state_next;
  logic       fin, fin_next;   // message closing: padding/output pending
  logic       last_blk, last_blk_next;
  logic       padded, padded_next;   // pad byte already in the buffer
  logic [2:0] widx, widx_next;
  logic       take;

  assign ready      = (state == S_IDLE);
  assign take       = valid && ready;
  assign out_valid  = (state == S_OUT);
  assign word_index = widx;
  assign last_word  = (widx == 3'd7);

  always_comb begin
    cmd           = '0;
    cmd.buf_sel   = FILL_MSG;
    state_next    = state;
    fin_next      = fin;
    last_blk_next = last_blk;
    padded_next   = padded;
    widx_next     = widx;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          fin_next      = end_of_message;
          last_blk_next = 1'b0;
          padded_next   = 1'b0;
          if (has_byte) begin
            cmd.buf_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
          if (has_byte && stat.fill == 6'd63) begin
            state_next = S_LOAD;
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.buf_wr  = 1'b1;
        cmd.buf_sel = FILL_PAD;
        padded_next = 1'b1;
        state_next  = (stat.fill == 6'd63) ? S_LOAD : S_ZERO;
        if (stat.fill == 6'd63) last_blk_next = 1'b0;
      end
      S_ZERO: begin
        // fill tracks buffer position, length counts message bytes only
        if (stat.fill == 6'(LenPos)) begin
          state_next = S_LEN;
        end else begin
          cmd.buf_wr  = 1'b1;
          cmd.buf_sel = FILL_ZERO;
          if (stat.fill == 6'd63) state_next = S_LOAD;
        end
      end
      S_LEN: begin
        cmd.len_wr    = 1'b1;
        last_blk_next = 1'b1;
        state_next    = S_LOAD;
      end
      S_LOAD: begin
        cmd.comp_start = 1'b1;
        state_next     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round == 6'd63) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.chain_upd = 1'b1;
        if (!fin) begin
          state_next = S_IDLE;
        end else if (last_blk) begin
          widx_next  = '0;
          state_next = S_OUT;
        end else if (padded) begin
          state_next = S_ZERO;
        end else begin
          state_next = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          widx_next = widx + 3'd1;
          if (widx == 3'd7) begin
            cmd.chain_init = 1'b1;
            cmd.cnt_clr    = 1'b1;
            fin_next       = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fin      <= 1'b0;
      last_blk <= 1'b0;
      padded   <= 1'b0;
      widx     <= '0;
    end else begin
      state    <= state_next;
      fin      <= fin_next;
      last_blk <= last_blk_next;
      padded   <= padded_next;
      widx     <= widx_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> fin && last_blk)
    else $error("digest output without closing message");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $past(state == S_ROUND) && $past(stat.round) == 6'd63)
    else $error("compression left early");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !ready)
    else $error("ready while busy");

endmodule

// ===== hw/rtl/sha256_message_digest.sv =====
// sha256_message_digest: top level of the byte-serial sha-256 hasher
// depends on sha_pkg, sha_ctrl, sha_datapath
// a byte that does not complete a block is taken while idle; a byte that
// completes a block is followed by a load, the round loop and a chain update
// end of message: pad and zero bytes one per cycle, then the length field
// write, then load, round loop and update per final block (one or two), then 8
// digest beats; the 64-round loop sets the throughput
// reset: chaining value to the initial hash, length count to zero, idle
module sha256_message_digest
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: takes one beat at a time, runs padding and the round loop
  sha_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .valid          (valid),
    .ready          (ready),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .word_index     (word_index),
    .last_word      (last_word),
    .stat           (stat),
    .cmd            (cmd)
  );

  // datapath: buffer, counter, schedule window, one round per cycle
  sha_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (data_byte),
    .rd_index  (word_index),
    .stat      (stat),
    .rd_word   (digest_word)
  );

endmodule

// ===== verif/testbench.sv =====
// testbench: regression for the byte-serial sha-256 hasher sha256_message_digest
// holds its own sha-256 predictor and a scoreboard of expected digest beats
// depends on sha_pkg and the sha256_message_digest rtl
module testbench
  import sha_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 200;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_message_digest dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: chaining value, partial block and byte count
  word_t       hash_state [8];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_bytes;
  digest_beat_t digest_queue [$];

  int errors = 0;
  int beats_sent = 0;
  int digests_seen = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  // round constants, typed out independently of the package
  word_t sha_k [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
  word_t sha_iv [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // fold msg_block into hash_state
  task automatic compress_block();
    word_t w [64];
    word_t v [8];
    word_t t1, t2, s0, s1;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = w[j-16] + s0 + w[j-7] + s1;
    end
    v = hash_state;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] += v[j];
  endtask

  // update the predictor with one accepted beat, queue a digest on end of message
  task automatic predict_digest(logic [7:0] b, logic hb, logic eom);
    int pos;
    logic [63:0] bit_len;
    digest_beat_t e;
    if (hb) begin
      msg_block[msg_bytes[5:0]] = b;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) compress_block();
    end
    if (!eom) return;
    pos = int'(msg_bytes[5:0]);
    msg_block[pos] = PadByte;
    pos++;
    if (pos > LenPos) begin
      while (pos < BlockBytes) begin msg_block[pos] = '0; pos++; end
      compress_block();
      pos = 0;
    end
    while (pos < LenPos) begin msg_block[pos] = '0; pos++; end
    bit_len = {msg_bytes, 3'b000};
    for (int k = 0; k < 8; k++) msg_block[LenPos + k] = bit_len[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      e.word = hash_state[k];
      e.idx  = 3'(k);
      e.last = (k == 7);
      digest_queue = {digest_queue, e};
    end
    hash_state = sha_iv;
    msg_bytes = '0;
  endtask

  // drive one beat, honoring the sender gap rate, and wait for acceptance
  // valid stays high after acceptance until a gap or a drain lowers it
  task automatic send_beat(logic [7:0] b, logic hb, logic eom);
    while ($urandom_range(99) < send_gap_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    data_byte <= b;
    has_byte <= hb;
    end_of_message <= eom;
    @(posedge clk);
    while (!ready) @(posedge clk);
    predict_digest(b, hb, eom);
    beats_sent++;
  endtask

  task automatic send_message(int len, bit eom_carries_byte);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom), 1'b1, (i == len - 1) && eom_carries_byte);
    if (!eom_carries_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    do @(posedge clk); while (digest_queue.size() != 0);
  endtask

  // directed: empty message, extreme bytes, idle beats, padding boundaries
  task automatic test_directed();
    send_beat(8'hff, 1'b0, 1'b1);               // empty message
    send_beat(8'h00, 1'b1, 1'b1);               // one zero byte on the end beat
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b0);               // idle beat in mid message
    send_beat(8'ha5, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);               // "abc"
    send_message(55, 1'b1);                     // pad and length fit one block
    send_message(56, 1'b1);                     // length spills into a second block
    send_message(64, 1'b0);                     // full block, then empty end beat
    wait_drained();
  endtask

  // random messages with random idle beats mixed in, mostly short lengths
  task automatic test_random(int n_beats);
    int len;
    while (beats_sent < n_beats) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b0);
      end
      send_beat(8'($urandom), 1'($urandom_range(1)), 1'b1);
    end
  endtask

  task automatic run_phase(int gap, int stall, int n_beats);
    send_gap_pct = gap;
    stall_pct = stall;
    test_random(beats_sent + n_beats);
    wait_drained();
  endtask

  // receiver: random stalls on out_ready
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // scoreboard: compare each accepted digest beat with the oldest expectation
  always @(posedge clk) begin
    digest_beat_t e;
    if (!rst && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest beat word=%h idx=%0d last=%b",
                 $time, digest_word, word_index, last_word);
        errors++;
      end else begin
        e = digest_queue.pop_front();
        if (digest_word !== e.word || word_index !== e.idx || last_word !== e.last) begin
          $display("%0t: digest mismatch expected word=%h idx=%0d last=%b, actual %h %0d %b",
                   $time, e.word, e.idx, e.last, digest_word, word_index, last_word);
          errors++;
        end
        if (e.last) digests_seen++;
      end
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("sha256_message_digest regression: fail");
      $finish;
    end
  end

  initial begin
    hash_state = sha_iv;
    msg_bytes = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_phase(0, 0, 30);
    run_phase(58, 0, 30);
    run_phase(0, 58, 30);
    run_phase(38, 38, 30);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d input beats and %0d digests over four idling phases",
             beats_sent, digests_seen);
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("sha256_message_digest regression: pass");
    end else begin
      $display("sha256_message_digest regression: fail");
    end
    $finish;
  end

endmodule
